FILE: sv/sst_pkg.sv
package sst_pkg;

  // Default table capacity and fixed field widths
  localparam int CAPACITY_DEF = 256;
  localparam int KEY_W        = 17;
  localparam int OUT_CNT_W    = 9;

  // Request operation codes
  localparam logic [1:0] OP_MEMBER = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Request item
  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                 success;
    logic                 table_full;
    logic [OUT_CNT_W-1:0] entry_count;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DECIDE,
    S_MV_CHK,
    S_MV_WR,
    S_PUT,
    S_DROP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture request, open search window
    logic probe;     // read entry at search midpoint
    logic cmp;       // narrow search window from read data
    logic init_ins;  // move pointer to end of list
    logic init_del;  // move pointer to found slot
    logic mv_rd;     // read source entry of a move
    logic mv_wr;     // write moved entry, step pointer
    logic put;       // write key at its slot, count up
    logic drop;      // count down
    logic finish;    // emit result
    logic res_ok;
    logic res_full;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic       srch_done;
    logic       found;
    logic       room;
    logic       mv_done;
    logic [1:0] op;
  } dp_stat_t;

endpackage

FILE: sv/sorted_set_table.sv
// Sorted key set: holds up to CAPACITY distinct 17-bit keys in ascending order
// and serves one request at a time (member test, insert, delete). Pulse start
// while busy is low; the request is taken at that edge. Exactly one result
// follows as a single-cycle out_valid strobe with out_data, and it must be
// captured then: there is no way to hold it off. Each request runs a binary
// search over the held keys (a probe and a compare state per step), then a
// decide state, and the result is registered. A changing insert or delete
// first shifts the entries after the slot (a read and a write state per
// entry), then ends in a put or drop state. The key memory takes one read or
// one moved entry at a time. A new request may be started in the cycle the
// result is shown. The key memory needs no clearing after reset.
module sorted_set_table
  import sst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Key memory, search window and counters
  sst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: sv/sst_dp.sv
module sst_dp
  import sst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Key memory, single write and single registered read
  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rdata_r;

  in_item_t         req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, ptr_r, ptr_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W:0]   ptr_inc;
  logic [CNT_W-1:0] ptr_dec;
  logic             is_ins;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] raddr, waddr;
  logic [KEY_W-1:0] wdata;
  logic [31:0]      cnt_ext;

  // Search midpoint and move pointer neighbors
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign ptr_inc = {1'b0, ptr_r} + {{CNT_W{1'b0}}, 1'b1};
  assign ptr_dec = ptr_r - {{(CNT_W-1){1'b0}}, 1'b1};
  assign is_ins  = (req_r.req_type == OP_INSERT);

  // Status
  assign stat.srch_done = (lo_r == hi_r);
  assign stat.found     = found_r;
  assign stat.room      = (count_r < CNT_W'(CAPACITY));
  assign stat.mv_done   = is_ins ? (ptr_r == lo_r) : (ptr_inc >= {1'b0, count_r});
  assign stat.op        = req_r.req_type;

  // Memory port selection
  always_comb begin
    rd_en = cmd.probe | cmd.mv_rd;
    wr_en = cmd.mv_wr | cmd.put;
    raddr = mid[IDX_W-1:0];
    if (cmd.mv_rd) begin
      raddr = is_ins ? ptr_dec[IDX_W-1:0] : ptr_inc[IDX_W-1:0];
    end
    waddr = cmd.put ? lo_r[IDX_W-1:0] : ptr_r[IDX_W-1:0];
    wdata = cmd.put ? req_r.key : rdata_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // Search window, move pointer and count
  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ptr_nxt   = ptr_r;
    found_nxt = found_r;
    count_nxt = count_r;
    if (cmd.load) begin
      lo_nxt    = '0;
      hi_nxt    = count_r;
      found_nxt = 1'b0;
    end
    if (cmd.cmp) begin
      if (rdata_r < req_r.key) begin
        lo_nxt = mid + {{(CNT_W-1){1'b0}}, 1'b1};
      end else begin
        hi_nxt = mid;
      end
      if (rdata_r == req_r.key) begin
        found_nxt = 1'b1;
      end
    end
    if (cmd.init_ins) ptr_nxt = count_r;
    if (cmd.init_del) ptr_nxt = lo_r;
    if (cmd.mv_wr) begin
      ptr_nxt = is_ins ? ptr_dec : ptr_inc[CNT_W-1:0];
    end
    if (cmd.put)  count_nxt = count_r + {{(CNT_W-1){1'b0}}, 1'b1};
    if (cmd.drop) count_nxt = count_r - {{(CNT_W-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      ptr_r   <= '0;
      found_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      ptr_r   <= ptr_nxt;
      found_r <= found_nxt;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
  end

  // Result register, count reported modulo 512
  assign cnt_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.success     <= cmd.res_ok;
      out_data_r.table_full  <= cmd.res_full;
      out_data_r.entry_count <= cnt_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("search window inverted");

  a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> count_r < CNT_W'(CAPACITY))
    else $error("key written into full table");

  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.success && out_data_r.table_full))
    else $error("success and full flag both set");
`endif

endmodule

FILE: sv/sst_ctrl.sv
module sst_ctrl
  import sst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_stat_t  stat,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.srch_done) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_PROBE;
      end
      S_DECIDE: begin
        case (stat.op)
          OP_MEMBER: begin
            cmd.finish = 1'b1;
            cmd.res_ok = stat.found;
            state_nxt  = S_IDLE;
          end
          OP_INSERT: begin
            if (stat.found || !stat.room) begin
              cmd.finish   = 1'b1;
              cmd.res_full = !stat.found;
              state_nxt    = S_IDLE;
            end else begin
              cmd.init_ins = 1'b1;
              state_nxt    = S_MV_CHK;
            end
          end
          OP_DELETE: begin
            if (stat.found) begin
              cmd.init_del = 1'b1;
              state_nxt    = S_MV_CHK;
            end else begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_MV_CHK: begin
        if (stat.mv_done) begin
          state_nxt = (stat.op == OP_INSERT) ? S_PUT : S_DROP;
        end else begin
          cmd.mv_rd = 1'b1;
          state_nxt = S_MV_WR;
        end
      end
      S_MV_WR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = S_MV_CHK;
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        cmd.finish = 1'b1;
        cmd.res_ok = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DROP: begin
        cmd.drop   = 1'b1;
        cmd.finish = 1'b1;
        cmd.res_ok = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

`ifndef ASSERT_OFF
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but controller not busy");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !busy)
    else $error("controller still busy after result");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.probe, cmd.cmp, cmd.mv_rd, cmd.mv_wr, cmd.put, cmd.drop}))
    else $error("conflicting datapath commands");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench
  import sst_pkg::*;
;

  // The fourth operation code does nothing in the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;
  // Worst item: full binary search plus a shift across the whole table
  localparam int SETTLE_CYCLES = 2 * CAPACITY_DEF + 64;
  localparam int STALL_LIMIT   = 20 * CAPACITY_DEF + 5000;

  // Mirror of the sorted key set and the queue of expected results
  class set_scoreboard;
    logic [KEY_W-1:0] held_keys[$];
    out_item_t        expected_q[$];
    int errors;
    int reported;
    int checked;
    int op_hits[4];
    int full_refusals;
    int peak_count;

    function int pending();
      return expected_q.size();
    endfunction

    function int held();
      return held_keys.size();
    endfunction

    function logic [KEY_W-1:0] any_held();
      if (held_keys.size() == 0) begin
        return '0;
      end
      return held_keys[$urandom_range(0, held_keys.size() - 1)];
    endfunction

    // Apply one accepted request to the mirror and queue its result
    function void note_request(in_item_t req);
      int        slot;
      bit        present;
      out_item_t res;
      slot = 0;
      while (slot < held_keys.size() && held_keys[slot] < req.key) slot++;
      present = (slot < held_keys.size()) && (held_keys[slot] == req.key);
      res = '0;
      case (req.req_type)
        OP_MEMBER: begin
          res.success = present;
        end
        OP_INSERT: begin
          if (!present) begin
            if (held_keys.size() >= CAPACITY_DEF) begin
              res.table_full = 1'b1;
              full_refusals++;
            end else begin
              held_keys.insert(slot, req.key);
              res.success = 1'b1;
            end
          end
        end
        OP_DELETE: begin
          if (present) begin
            held_keys.delete(slot);
            res.success = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.entry_count = OUT_CNT_W'(held_keys.size());
      if (res.success) op_hits[req.req_type]++;
      if (held_keys.size() > peak_count) peak_count = held_keys.size();
      expected_q.push_back(res);
    endfunction

    // Compare one result against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          $display("%0t: result with nothing expected: success=%0b full=%0b count=%0d",
                   $realtime, got.success, got.table_full, got.entry_count);
          reported++;
        end
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.success !== want.success || got.table_full !== want.table_full ||
          got.entry_count !== want.entry_count) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          $display("%0t: mismatch on result %0d: exp success=%0b full=%0b count=%0d, %s",
                   $realtime, checked, want.success, want.table_full, want.entry_count,
                   $sformatf("got success=%0b full=%0b count=%0d",
                             got.success, got.table_full, got.entry_count));
          reported++;
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  set_scoreboard sb;
  int idle_pct;
  int n_sent;
  int stall_cycles;

  sorted_set_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor: check results first, then record the request taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) begin
        sb.note_request(in_data);
        n_sent++;
      end
      if (out_valid || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 stall_cycles, sb.pending());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t mk(logic [1:0] op, logic [KEY_W-1:0] k);
    in_item_t it;
    it.req_type = op;
    it.key      = k;
    return it;
  endfunction

  // Keys biased toward held entries, a dense low pool and the top of the range
  function automatic logic [KEY_W-1:0] rand_key(int held_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < held_pct && sb.held() > 0) return sb.any_held();
    r = $urandom_range(0, 99);
    if (r < 50) return KEY_W'($urandom_range(0, 63));
    if (r < 65) return KEY_W'($urandom_range(17'h1FFC0, 17'h1FFFF));
    return KEY_W'($urandom);
  endfunction

  function automatic logic [1:0] rand_op(int ins_w, int del_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return OP_UNUSED;
    if (r < 4 + ins_w) return OP_INSERT;
    if (r < 4 + ins_w + del_w) return OP_DELETE;
    return OP_MEMBER;
  endfunction

  // Issue one request, idling at random first, and return at its acceptance edge
  task automatic send(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= in_item_t'($urandom);
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic directed_items();
    send(mk(OP_MEMBER, 17'h00000));   // empty table
    send(mk(OP_DELETE, 17'h1FFFF));   // delete from empty table
    send(mk(OP_INSERT, 17'h1FFFF));
    send(mk(OP_INSERT, 17'h00000));
    send(mk(OP_INSERT, 17'h10000));   // top bit of the key set
    send(mk(OP_INSERT, 17'h0FFFF));
    send(mk(OP_INSERT, 17'h00000));   // already held
    send(mk(OP_MEMBER, 17'h1FFFF));
    send(mk(OP_MEMBER, 17'h10000));
    send(mk(OP_MEMBER, 17'h00005));   // absent
    send(mk(OP_UNUSED, 17'h00000));
    send(mk(OP_UNUSED, 17'h1FFFF));
    send(mk(OP_DELETE, 17'h00007));   // absent
    send(mk(OP_DELETE, 17'h0FFFF));   // middle entry
    send(mk(OP_DELETE, 17'h1FFFF));   // last entry
    send(mk(OP_DELETE, 17'h00000));   // first entry
    send(mk(OP_INSERT, 17'h00001));
    send(mk(OP_MEMBER, 17'h10000));
    send(mk(OP_DELETE, 17'h10000));
    send(mk(OP_DELETE, 17'h00001));   // table empty again
  endtask

  initial begin
    sb = new;
    n_sent       = 0;
    stall_cycles = 0;
    idle_pct     = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    drain();

    // Mixed traffic at small and medium fill, sender idles a third of the time
    idle_pct = 33;
    repeat (300) send(mk(rand_op(40, 25), rand_key(40)));
    drain();

    // Fill to capacity, then hover at the full mark
    idle_pct = 63;
    while (sb.held() < CAPACITY_DEF) begin
      send(mk(OP_INSERT, ($urandom_range(0, 9) == 0) ? rand_key(100) : KEY_W'($urandom)));
    end
    repeat (80) send(mk(rand_op(50, 20), rand_key(50)));
    drain();

    // Back-to-back traffic, delete heavy, then empty the table
    idle_pct = 0;
    repeat (250) send(mk(rand_op(20, 45), rand_key(60)));
    while (sb.held() > 0) send(mk(OP_DELETE, sb.any_held()));
    send(mk(OP_MEMBER, KEY_W'($urandom)));

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d results; peak fill %0d of %0d, %0d full refusals",
             n_sent, sb.checked, sb.peak_count, CAPACITY_DEF, sb.full_refusals);
    $display("Hits: %0d member, %0d insert, %0d delete; %0d mismatches",
             sb.op_hits[OP_MEMBER], sb.op_hits[OP_INSERT], sb.op_hits[OP_DELETE], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
